/* src/assert_macros.svh */
// Assertion macros used by the checker file of the array store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define GARR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("garr: same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define GARR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("garr: next-cycle check failed");

`endif

/* src/garr_pkg.sv */
// Package of the growable array store: sizes, codes and controller-datapath types.
`default_nettype none
package garr_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;

    localparam logic [DATA_W-1:0] UNDEF_MARK = 32'h8000_0001;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_WAIT,
        S_FILL,
        S_SHIFT
    } t_state;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_LEN,
        PTR_IDX,
        PTR_INC
    } t_ptr_op;

    typedef enum logic [1:0] {
        WD_MARK,
        WD_VALUE,
        WD_RDATA
    } t_wdata_sel;

    typedef enum logic {
        WA_PTR,
        WA_IDX
    } t_waddr_sel;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX1,
        RA_PTR2
    } t_raddr_sel;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_GROW,
        LEN_SHRINK
    } t_len_op;

    typedef enum logic [1:0] {
        RV_ZERO,
        RV_MARK,
        RV_RDATA
    } t_rv_sel;

    typedef struct packed {
        logic       load;
        t_ptr_op    ptr_op;
        logic       we;
        t_wdata_sel wdata_sel;
        t_waddr_sel waddr_sel;
        t_raddr_sel raddr_sel;
        t_len_op    len_op;
        logic       emit;
        t_status    res_status;
        t_rv_sel    rv_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  idx_in_len;
        logic  idx_in_depth;
        logic  idx1_in_len;
        logic  ptr_below_idx;
        logic  ptr2_in_len;
    } t_dp_status;

endpackage
`default_nettype wire

/* src/garr_ctrl.sv */
// Controller state machine of the growable array store.
`default_nettype none
module garr_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire garr_pkg::t_dp_status i_stat,
    output garr_pkg::t_dp_cmd         o_cmd,
    output logic                      o_busy
);
    import garr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    KIND_READ:   n_state = i_stat.idx_in_len ? S_READ_WAIT : S_IDLE;
                    KIND_WRITE:  n_state = i_stat.idx_in_depth ? S_FILL : S_IDLE;
                    KIND_DELETE: n_state = (i_stat.idx_in_len && i_stat.idx1_in_len) ?
                                           S_SHIFT : S_IDLE;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_READ_WAIT: n_state = S_IDLE;
            S_FILL: begin
                if (!i_stat.ptr_below_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!i_stat.ptr2_in_len) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd            = '0;
        o_cmd.ptr_op     = PTR_HOLD;
        o_cmd.wdata_sel  = WD_MARK;
        o_cmd.waddr_sel  = WA_PTR;
        o_cmd.raddr_sel  = RA_IDX;
        o_cmd.len_op     = LEN_HOLD;
        o_cmd.res_status = ST_OK;
        o_cmd.rv_sel     = RV_ZERO;
        o_busy           = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    KIND_READ: begin
                        if (i_stat.idx_in_len) begin
                            o_cmd.raddr_sel = RA_IDX;
                        end else begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                            o_cmd.rv_sel     = RV_MARK;
                        end
                    end
                    KIND_WRITE: begin
                        if (i_stat.idx_in_depth) begin
                            o_cmd.ptr_op = PTR_LEN;
                        end else begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end
                    end
                    KIND_DELETE: begin
                        if (!i_stat.idx_in_len) begin
                            o_cmd.emit       = 1'b1;
                            o_cmd.res_status = ST_RANGE;
                        end else if (i_stat.idx1_in_len) begin
                            o_cmd.ptr_op    = PTR_IDX;
                            o_cmd.raddr_sel = RA_IDX1;
                        end else begin
                            o_cmd.len_op = LEN_SHRINK;
                            o_cmd.emit   = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                    end
                endcase
            end
            S_READ_WAIT: begin
                o_cmd.emit   = 1'b1;
                o_cmd.rv_sel = RV_RDATA;
            end
            S_FILL: begin
                o_cmd.we = 1'b1;
                if (i_stat.ptr_below_idx) begin
                    o_cmd.wdata_sel = WD_MARK;
                    o_cmd.waddr_sel = WA_PTR;
                    o_cmd.ptr_op    = PTR_INC;
                end else begin
                    o_cmd.wdata_sel = WD_VALUE;
                    o_cmd.waddr_sel = WA_IDX;
                    o_cmd.len_op    = LEN_GROW;
                    o_cmd.emit      = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.we        = 1'b1;
                o_cmd.wdata_sel = WD_RDATA;
                o_cmd.waddr_sel = WA_PTR;
                if (i_stat.ptr2_in_len) begin
                    o_cmd.raddr_sel = RA_PTR2;
                    o_cmd.ptr_op    = PTR_INC;
                end else begin
                    o_cmd.len_op = LEN_SHRINK;
                    o_cmd.emit   = 1'b1;
                end
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/garr_dp.sv */
// Datapath of the growable array store: element memory, length, walk pointer, result registers.
`default_nettype none
module garr_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire garr_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [1:0]                          i_kind,
    input  wire logic [garr_pkg::IDX_W-1:0]          i_index,
    input  wire logic signed [garr_pkg::DATA_W-1:0]  i_value,
    output garr_pkg::t_dp_status                     o_stat,
    output logic                                     o_valid,
    output logic signed [garr_pkg::DATA_W-1:0]       o_read_value,
    output logic [1:0]                               o_status,
    output logic [garr_pkg::LEN_W-1:0]               o_length
);
    import garr_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    t_kind             r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_value;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [LEN_W-1:0]  r_ptr;
    logic [LEN_W-1:0]  n_ptr;
    logic [DATA_W-1:0] r_rdata;
    logic              r_valid;
    logic [DATA_W-1:0] r_rv;
    logic [1:0]        r_st;
    logic [LEN_W-1:0]  r_olen;

    logic [IDX_W:0]    idx_plus1;
    logic [LEN_W:0]    ptr_plus2;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rv_sel;

    assign idx_plus1 = {1'b0, r_idx} + (IDX_W + 1)'(1);
    assign ptr_plus2 = {1'b0, r_ptr} + (LEN_W + 1)'(2);

    assign o_stat.kind          = r_kind;
    assign o_stat.idx_in_len    = 32'(r_idx) < 32'(r_len);
    assign o_stat.idx_in_depth  = 32'(r_idx) < 32'(DEPTH);
    assign o_stat.idx1_in_len   = 32'(idx_plus1) < 32'(r_len);
    assign o_stat.ptr_below_idx = 32'(r_ptr) < 32'(r_idx);
    assign o_stat.ptr2_in_len   = 32'(ptr_plus2) < 32'(r_len);

    always_comb begin
        case (i_cmd.waddr_sel)
            WA_IDX:  waddr = r_idx[ADDR_W-1:0];
            default: waddr = r_ptr[ADDR_W-1:0];
        endcase
        case (i_cmd.raddr_sel)
            RA_IDX1: raddr = idx_plus1[ADDR_W-1:0];
            RA_PTR2: raddr = ptr_plus2[ADDR_W-1:0];
            default: raddr = r_idx[ADDR_W-1:0];
        endcase
        case (i_cmd.wdata_sel)
            WD_VALUE: wdata = r_value;
            WD_RDATA: wdata = r_rdata;
            default:  wdata = UNDEF_MARK;
        endcase
        case (i_cmd.rv_sel)
            RV_MARK:  rv_sel = UNDEF_MARK;
            RV_RDATA: rv_sel = r_rdata;
            default:  rv_sel = '0;
        endcase
        case (i_cmd.len_op)
            LEN_GROW:   n_len = o_stat.idx_in_len ? r_len : LEN_W'(idx_plus1);
            LEN_SHRINK: n_len = r_len - LEN_W'(1);
            default:    n_len = r_len;
        endcase
        case (i_cmd.ptr_op)
            PTR_LEN: n_ptr = r_len;
            PTR_IDX: n_ptr = LEN_W'(r_idx);
            PTR_INC: n_ptr = r_ptr + LEN_W'(1);
            default: n_ptr = r_ptr;
        endcase
    end

    // Element memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // Latched transaction fields and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_kind);
            r_idx   <= i_index;
            r_value <= i_value;
        end
        if (i_cmd.emit) begin
            r_rv   <= rv_sel;
            r_st   <= i_cmd.res_status;
            r_olen <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_ptr   <= n_ptr;
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_rv;
    assign o_status     = r_st;
    assign o_length     = r_olen;

endmodule
`default_nettype wire

/* src/growable_array_with_shift_delete.sv */
// Top level of the growable array store with shift-down delete.
//
//  Port group    Direction  Handshake              Contents
//  command       in         start / busy           i_kind, i_index, i_value
//  result        out        o_valid (one cycle)    o_read_value, o_status, o_length
//
// A transaction is taken at a rising edge where start is high and busy is low.
// A read goes through a registered memory read to its result, or ends with a range status
// when out of range; a write fills each gap slot between the length and the index with the
// marker, then writes the value, or is dropped when the index is beyond the depth; a delete
// moves each element above the index down, then shrinks the length. One memory entry is walked per cycle.
// Reset is synchronous and clears the length; the result port cannot be stalled.
`default_nettype none
module growable_array_with_shift_delete (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic [1:0]                          i_kind,
    input  wire logic [garr_pkg::IDX_W-1:0]          i_index,
    input  wire logic signed [garr_pkg::DATA_W-1:0]  i_value,
    output logic                                     busy,
    output logic                                     o_valid,
    output logic signed [garr_pkg::DATA_W-1:0]       o_read_value,
    output logic [1:0]                               o_status,
    output logic [garr_pkg::LEN_W-1:0]               o_length
);
    import garr_pkg::*;

    // Commands flow from the controller to the datapath, and compare results
    // flow back; the two halves share nothing else but clock and reset.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_stat;

    garr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    garr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_kind       (i_kind),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_stat       (dp_stat),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_length     (o_length)
    );

endmodule
`default_nettype wire

/* src/garr_checker.sv */
// Port-level checker of the growable array store and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module garr_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic                                o_valid,
    input  wire logic signed [garr_pkg::DATA_W-1:0]  o_read_value,
    input  wire logic [1:0]                          o_status,
    input  wire logic [garr_pkg::LEN_W-1:0]          o_length
);
    import garr_pkg::*;

    `GARR_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `GARR_ASSERT_IMP(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `GARR_ASSERT_NXT(a_single_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `GARR_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, o_valid, 32'(o_length) <= 32'(DEPTH))
    `GARR_ASSERT_IMP(a_full_zero, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_read_value == 0)

endmodule

bind growable_array_with_shift_delete garr_checker u_garr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_read_value (o_read_value),
    .o_status     (o_status),
    .o_length     (o_length)
);
`default_nettype wire
